### design/tmoc_pkg.sv
`timescale 1ns / 1ps

package tmoc_pkg;

    localparam int BYTE_W      = 8;
    localparam int MSS_W       = 16;
    localparam int POS_W       = 6;
    localparam int HLEN_W      = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register indexes
    localparam logic REG_MAX_MSS = 1'b0;

    localparam logic [MSS_W-1:0] MAX_MSS_RESET = 16'd1460;

    // one queue entry: one output byte, or the two bytes of the mss value
    typedef struct packed {
        logic              two;
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic              last;
        logic              rewritten;
    } tmoc_entry_t;

    // one output byte as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              rewritten;
    } tmoc_beat_t;

endpackage

### design/tmoc_if.sv
`timescale 1ns / 1ps

// segment byte stream into the block
interface tmoc_in_if;
    logic                       valid;
    logic                       ready;
    logic [tmoc_pkg::BYTE_W-1:0] seg_byte;
    logic                       seg_last;

    modport source (output valid, output seg_byte, output seg_last, input ready);
    modport sink   (input valid, input seg_byte, input seg_last, output ready);
endinterface

// rewritten byte stream out of the block
interface tmoc_out_if;
    logic                       valid;
    logic                       ready;
    logic [tmoc_pkg::BYTE_W-1:0] out_byte;
    logic                       out_last;
    logic                       rewritten;

    modport source (output valid, output out_byte, output out_last, output rewritten,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input rewritten,
                    output ready);
endinterface

### design/tcp_mss_option_clamp.sv
`timescale 1ns / 1ps

// TCP MSS clamp: takes segment bytes from the first header byte on, one per cycle while the
// queue is not full, and passes them on unchanged except for the value of the first MSS
// option (kind 2, length 4), replaced by max_mss when larger; the checksum is not touched. The
// parser holds the MSS high byte until the low byte arrives and queues the pair as one entry.
// The output register emits one byte per cycle while seg_out is ready, the low byte via a
// pending slot; the extra beat is absorbed by a four-entry queue between parser and output
// stage. Bytes pass a queue slot and the output register. max_mss sits at APB address 0
// (reset 1460); the user must write it only while no segment is in flight (not enforced).
module tcp_mss_option_clamp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmoc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tmoc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tmoc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    tmoc_in_if.sink                         seg_in,
    tmoc_out_if.source                      seg_out
);
    import tmoc_pkg::*;

    logic [MSS_W-1:0] max_mss_reg;
    logic             reg_sel;
    logic             cfg_write;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    tmoc_entry_t      push_entry;
    tmoc_entry_t      pop_entry;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_mss_reg <= MAX_MSS_RESET;
        end
        else if (cfg_write && reg_sel == REG_MAX_MSS)
        begin
            max_mss_reg <= pwdata[MSS_W-1:0];
        end
    end

    // register read back
    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_MAX_MSS)
        begin
            prdata = APB_DATA_W'(max_mss_reg);
        end
    end

    tmoc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_mss    (max_mss_reg),
        .seg_in     (seg_in),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    tmoc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    tmoc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_entry  (pop_entry),
        .empty      (empty),
        .pop        (pop),
        .seg_out    (seg_out)
    );

endmodule

### design/tmoc_front.sv
`timescale 1ns / 1ps

module tmoc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tmoc_pkg::MSS_W-1:0] max_mss,
    tmoc_in_if.sink                    seg_in,
    input  logic                       queue_full,
    output logic                       push,
    output tmoc_pkg::tmoc_entry_t      push_entry
);
    import tmoc_pkg::*;

    typedef enum logic [6:0] {
        PH_KIND      = 7'b0000001,
        PH_LEN_MSS   = 7'b0000010,
        PH_LEN_OTHER = 7'b0000100,
        PH_SKIP      = 7'b0001000,
        PH_MSS_HI    = 7'b0010000,
        PH_MSS_LO    = 7'b0100000,
        PH_DONE      = 7'b1000000
    } phase_t;

    localparam logic [POS_W-1:0]  POS_DATA_OFFSET = POS_W'(12);
    localparam logic [POS_W-1:0]  POS_OPTIONS     = POS_W'(20);
    localparam logic [POS_W-1:0]  POS_MAX         = {POS_W{1'b1}};
    localparam logic [BYTE_W-1:0] KIND_END        = BYTE_W'(0);
    localparam logic [BYTE_W-1:0] KIND_NOP        = BYTE_W'(1);
    localparam logic [BYTE_W-1:0] KIND_MSS        = BYTE_W'(2);
    localparam logic [BYTE_W-1:0] LEN_MIN         = BYTE_W'(2);
    localparam logic [BYTE_W-1:0] LEN_MSS         = BYTE_W'(4);
    localparam int                SUM_W           = BYTE_W + 1;

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [HLEN_W-1:0]   hlen_reg, hlen_next;
    logic [POS_W-1:0]    left_reg, left_next;
    logic [BYTE_W-1:0]   held_reg, held_next;

    logic                accept;
    logic                emit;
    logic [BYTE_W-1:0]   b;
    logic [POS_W:0]      pos_plus1;
    logic [SUM_W-1:0]    opt_end;
    logic [BYTE_W-1:0]   len_minus2;
    logic [MSS_W-1:0]    mss_value;

    assign seg_in.ready = !queue_full;
    assign accept       = seg_in.valid && seg_in.ready;
    assign push         = accept && emit;
    assign b            = seg_in.seg_byte;
    assign pos_plus1    = {1'b0, pos_reg} + 7'd1;
    assign opt_end      = SUM_W'(pos_reg) - SUM_W'(1) + SUM_W'(b);
    assign len_minus2   = b - LEN_MIN;
    assign mss_value    = {held_reg, b};

    // option walk and classification of the current byte
    always_comb
    begin
        phase_next = phase_reg;
        hlen_next  = hlen_reg;
        left_next  = left_reg;
        held_next  = held_reg;
        emit       = 1'b1;

        push_entry.two         = 1'b0;
        push_entry.first_byte  = b;
        push_entry.second_byte = b;
        push_entry.last        = seg_in.seg_last;
        push_entry.rewritten   = 1'b0;

        if (pos_reg == POS_DATA_OFFSET)
        begin
            hlen_next = {b[7:4], 2'b00};
        end

        if (pos_reg >= POS_OPTIONS)
        begin
            unique case (phase_reg)
                PH_KIND:
                begin
                    if (pos_reg >= hlen_reg || b == KIND_END)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (b == KIND_NOP)
                    begin
                        phase_next = PH_KIND;
                    end
                    else if (pos_plus1 >= {1'b0, hlen_reg})
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = (b == KIND_MSS) ? PH_LEN_MSS : PH_LEN_OTHER;
                    end
                end
                PH_LEN_MSS, PH_LEN_OTHER:
                begin
                    if (b < LEN_MIN || opt_end > SUM_W'(hlen_reg))
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (phase_reg == PH_LEN_MSS && b == LEN_MSS)
                    begin
                        phase_next = PH_MSS_HI;
                    end
                    else
                    begin
                        left_next  = len_minus2[POS_W-1:0];
                        phase_next = (len_minus2[POS_W-1:0] == '0) ? PH_KIND : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_reg - POS_W'(1);
                    if (left_reg == POS_W'(1))
                    begin
                        phase_next = PH_KIND;
                    end
                end
                PH_MSS_HI:
                begin
                    // a segment ending here releases the byte as it is
                    if (!seg_in.seg_last)
                    begin
                        held_next  = b;
                        phase_next = PH_MSS_LO;
                        emit       = 1'b0;
                    end
                end
                PH_MSS_LO:
                begin
                    push_entry.two = 1'b1;
                    if (mss_value > max_mss)
                    begin
                        push_entry.first_byte  = max_mss[15:8];
                        push_entry.second_byte = max_mss[7:0];
                        push_entry.rewritten   = 1'b1;
                    end
                    else
                    begin
                        push_entry.first_byte  = held_reg;
                        push_entry.second_byte = b;
                    end
                    phase_next = PH_DONE;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end

        pos_next = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
    end

    // per-segment state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KIND;
            pos_reg   <= '0;
            hlen_reg  <= '0;
            left_reg  <= '0;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            if (seg_in.seg_last)
            begin
                phase_reg <= PH_KIND;
                pos_reg   <= '0;
                hlen_reg  <= '0;
                left_reg  <= '0;
                held_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                hlen_reg  <= hlen_next;
                left_reg  <= left_next;
                held_reg  <= held_next;
            end
        end
    end

endmodule

### design/tmoc_queue.sv
`timescale 1ns / 1ps

module tmoc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tmoc_pkg::tmoc_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output tmoc_pkg::tmoc_entry_t pop_entry,
    output logic                  empty
);
    import tmoc_pkg::*;

    tmoc_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/tmoc_back.sv
`timescale 1ns / 1ps

module tmoc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tmoc_pkg::tmoc_entry_t pop_entry,
    input  logic                  empty,
    output logic                  pop,
    tmoc_out_if.source            seg_out
);
    import tmoc_pkg::*;

    logic        out_valid_reg;
    tmoc_beat_t  out_beat_reg;
    logic        pend_valid_reg;
    tmoc_beat_t  pend_beat_reg;
    logic        load_ok;

    assign load_ok = !out_valid_reg || seg_out.ready;
    assign pop     = load_ok && !pend_valid_reg && !empty;

    assign seg_out.valid     = out_valid_reg;
    assign seg_out.out_byte  = out_beat_reg.data;
    assign seg_out.out_last  = out_beat_reg.last;
    assign seg_out.rewritten = out_beat_reg.rewritten;

    // output register control, second mss byte waits in the pending slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= !empty;
                pend_valid_reg <= !empty && pop_entry.two;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            if (pend_valid_reg)
            begin
                out_beat_reg <= pend_beat_reg;
            end
            else if (!empty)
            begin
                out_beat_reg.data      <= pop_entry.first_byte;
                out_beat_reg.last      <= pop_entry.last && !pop_entry.two;
                out_beat_reg.rewritten <= pop_entry.rewritten;
                pend_beat_reg.data      <= pop_entry.second_byte;
                pend_beat_reg.last      <= pop_entry.last;
                pend_beat_reg.rewritten <= pop_entry.rewritten;
            end
        end
    end

endmodule
